// ===== rtl/ttps_pkg.sv =====
package ttps_pkg;

  typedef enum logic {
    REQ_PROBE = 1'b0,
    REQ_STORE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_LOWER = 2'd1,
    BOUND_UPPER = 2'd2
  } bound_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 6;
  localparam int SCORE_W = 32;
  localparam int HINT_W  = 10;

  typedef struct packed {
    req_kind_t                  req_type;
    logic [KEY_W-1:0]           position_key;
    logic [DEPTH_W-1:0]         search_depth;
    logic signed [SCORE_W-1:0]  window_low;
    logic signed [SCORE_W-1:0]  window_high;
    logic signed [SCORE_W-1:0]  store_score;
    logic [HINT_W-1:0]          store_move;
  } req_item_t;

  typedef struct packed {
    logic                       key_match;
    logic [HINT_W-1:0]          hint_move;
    logic                       cutoff;
    logic signed [SCORE_W-1:0]  cutoff_score;
    logic                       fail_low;
    logic                       fail_high;
    logic signed [SCORE_W-1:0]  narrowed_alpha;
    logic signed [SCORE_W-1:0]  narrowed_beta;
    bound_t                     bound_kind;
  } rsp_item_t;

  // Slot contents as seen by the evaluator, move already resized to port width
  typedef struct packed {
    logic                       valid;
    logic [KEY_W-1:0]           key;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SCORE_W-1:0]  score;
    bound_t                     bound;
    logic [HINT_W-1:0]          move;
  } slot_view_t;

endpackage

// ===== rtl/ttps_stream_if.sv =====
interface ttps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/transposition_table_probe_store.sv =====
// Direct-mapped transposition table. Each request transaction is a probe or a
// store; the slot is the low log2(TABLE_SLOTS) bits of position_key, and every
// request returns exactly one response transaction. The accept edge issues the
// read of the single-port slot memory; a later edge, once the response register
// is free, evaluates the registered entry, loads the response register and,
// for a store, writes the slot back. The next request is taken only once that
// write-back is done, so no new request is accepted while one is in flight.
// After reset the block sweeps the memory clearing one slot per cycle, and
// takes no request until the sweep ends.
module transposition_table_probe_store #(
  parameter int TABLE_SLOTS = 4096,
  parameter int MOVE_BITS   = 10
) (
  input  logic         clk,
  input  logic         rst,
  ttps_stream_if.sink   req,
  ttps_stream_if.source rsp
);
  import ttps_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    bound_t                    bound;
    logic [MOVE_BITS-1:0]      move;
  } entry_t;

  entry_t mem [TABLE_SLOTS];

  state_t     state;
  state_t     state_next;
  logic [IDX_W-1:0] clr_idx;
  req_item_t  req_q;
  entry_t     rdata;
  slot_view_t slot;
  rsp_item_t  res;
  logic       accept;
  logic       out_free;
  logic       finish;
  logic       mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t     mem_wdata;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign finish   = (state == ST_EVAL) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IDX_W'(TABLE_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Single write port: sweep writes and store write-backs never coincide
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (finish && req_q.req_type == REQ_STORE) begin
      mem_we          = 1'b1;
      mem_waddr       = req_q.position_key[IDX_W-1:0];
      mem_wdata.valid = 1'b1;
      mem_wdata.key   = req_q.position_key;
      mem_wdata.depth = req_q.search_depth;
      mem_wdata.score = req_q.store_score;
      mem_wdata.bound = res.bound_kind;
      mem_wdata.move  = MOVE_BITS'(req_q.store_move);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata <= mem[req.data.position_key[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.data;
    end
  end

  assign slot.valid = rdata.valid;
  assign slot.key   = rdata.key;
  assign slot.depth = rdata.depth;
  assign slot.score = rdata.score;
  assign slot.bound = rdata.bound;
  assign slot.move  = HINT_W'(rdata.move);

  ttps_eval u_eval (
    .req  (req_q),
    .slot (slot),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.data <= res;
    end
  end

endmodule

// ===== rtl/ttps_eval.sv =====
module ttps_eval (
  input  ttps_pkg::req_item_t  req,
  input  ttps_pkg::slot_view_t slot,
  output ttps_pkg::rsp_item_t  res
);
  import ttps_pkg::*;

  logic signed [SCORE_W-1:0] alpha;
  logic signed [SCORE_W-1:0] beta;
  logic signed [SCORE_W-1:0] v;
  logic le_alpha;
  logic ge_beta;
  logic crossed;
  logic hit;
  logic deep;
  logic settle;

  assign alpha    = req.window_low;
  assign beta     = req.window_high;
  assign v        = (req.req_type == REQ_STORE) ? req.store_score : slot.score;
  assign le_alpha = v <= alpha;
  assign ge_beta  = v >= beta;
  assign crossed  = alpha >= beta;
  assign hit      = slot.valid && (slot.key == req.position_key);
  assign deep     = slot.depth >= req.search_depth;

  // Cutoff when the entry is exact or the narrowed window crosses: judged from parallel compares, no chained max/min
  always_comb begin
    case (slot.bound)
      BOUND_EXACT: settle = 1'b1;
      BOUND_LOWER: settle = le_alpha ? crossed : ge_beta;
      BOUND_UPPER: settle = ge_beta ? crossed : le_alpha;
      default:     settle = crossed;
    endcase
  end

  always_comb begin
    res                = '0;
    res.narrowed_alpha = alpha;
    res.narrowed_beta  = beta;
    res.bound_kind     = BOUND_EXACT;
    if (req.req_type == REQ_STORE) begin
      if (le_alpha) begin
        res.bound_kind = BOUND_UPPER;
      end else if (ge_beta) begin
        res.bound_kind = BOUND_LOWER;
      end
      res.fail_low  = le_alpha;
      res.fail_high = ge_beta;
    end else if (hit) begin
      res.key_match  = 1'b1;
      res.hint_move  = slot.move;
      res.bound_kind = slot.bound;
      if (deep) begin
        if (slot.bound == BOUND_LOWER && !le_alpha) begin
          res.narrowed_alpha = v;
        end
        if (slot.bound == BOUND_UPPER && !ge_beta) begin
          res.narrowed_beta = v;
        end
        if (settle) begin
          res.cutoff       = 1'b1;
          res.cutoff_score = v;
          res.fail_low     = le_alpha;
          res.fail_high    = ge_beta;
        end
      end
    end
  end

endmodule
